[sv/elfd_pkg.sv]
// Shared types, codes and constants of the escaped length frame deframer.
package elfd_pkg;

  // Longest accepted payload length plus one; the 7-bit counts cap it at 128.
  localparam int MaxFrameLen = 128;
  localparam int CountLimit  = 128;
  localparam logic [8:0] LenLimit =
    9'((MaxFrameLen < CountLimit) ? MaxFrameLen : CountLimit);

  localparam logic [7:0] ByteStart    = 8'hFF;
  localparam logic [7:0] ByteEnd      = 8'hFE;
  localparam logic [7:0] ByteEscape   = 8'hFD;
  localparam logic [7:0] EscapeOffset = 8'hF0;
  localparam logic [7:0] ByteStop     = 8'hFC;
  localparam logic [7:0] ByteContinue = 8'hFB;

  localparam logic [1:0] PhaseIdle    = 2'd0;
  localparam logic [1:0] PhaseLength  = 2'd1;
  localparam logic [1:0] PhasePayload = 2'd2;

  localparam logic [2:0] KindData   = 3'd0;
  localparam logic [2:0] KindOk     = 3'd1;
  localparam logic [2:0] KindBadEnd = 3'd2;
  localparam logic [2:0] KindBadLen = 3'd3;
  localparam logic [2:0] KindStray  = 3'd4;
  localparam logic [2:0] KindFlow   = 3'd5;

  typedef struct packed {
    logic [1:0] frame_phase;
    logic       escape_pending;
    logic [6:0] bytes_remaining;
    logic [6:0] bytes_received;
    logic       stopped_flag;
  } frame_state_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] data_byte;
    logic [6:0] frame_length;
    logic       link_stopped;
  } result_t;

endpackage

[sv/elfd_if.sv]
// Handshake interfaces for the received byte channel and the result channel.
interface elfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface elfd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] data_byte;
  logic [6:0] frame_length;
  logic       link_stopped;

  modport source (output valid, output result_kind, output data_byte,
                  output frame_length, output link_stopped, input ready);
  modport sink (input valid, input result_kind, input data_byte,
                input frame_length, input link_stopped, output ready);
endinterface

[sv/elfd_step.sv]
// Per-byte frame phase logic: next state and the optional result of one byte.
module elfd_step
  import elfd_pkg::*;
(
  input  logic [7:0]   rx_byte,
  input  frame_state_t state,
  output frame_state_t state_next,
  output logic         has_result,
  output result_t      result
);

  logic [7:0] plain_byte;
  logic [6:0] count_inc;

  assign plain_byte = state.escape_pending ? 8'(rx_byte + EscapeOffset) : rx_byte;
  assign count_inc  = 7'(state.bytes_received + 7'd1);

  always_comb begin
    state_next           = state;
    has_result           = 1'b0;
    result.result_kind   = KindStray;
    result.data_byte     = rx_byte;
    result.frame_length  = 7'd0;
    case (state.frame_phase)
      PhaseLength: begin
        if ({1'b0, rx_byte} < LenLimit) begin
          state_next.frame_phase     = PhasePayload;
          state_next.bytes_remaining = rx_byte[6:0];
        end else begin
          has_result         = 1'b1;
          result.result_kind = KindBadLen;
          if (rx_byte == ByteStart) begin
            state_next.frame_phase     = PhaseLength;
            state_next.escape_pending  = 1'b0;
            state_next.bytes_remaining = 7'd0;
            state_next.bytes_received  = 7'd0;
          end else begin
            state_next.frame_phase = PhaseIdle;
          end
        end
      end
      PhasePayload: begin
        if (rx_byte == ByteEscape) begin
          state_next.escape_pending = 1'b1;
        end else begin
          state_next.escape_pending = 1'b0;
          has_result                = 1'b1;
          result.data_byte          = plain_byte;
          if (state.bytes_remaining != 7'd0) begin
            state_next.bytes_remaining = 7'(state.bytes_remaining - 7'd1);
            state_next.bytes_received  = count_inc;
            result.result_kind         = KindData;
            result.frame_length        = count_inc;
          end else if (plain_byte == ByteEnd) begin
            state_next.frame_phase = PhaseIdle;
            result.result_kind     = KindOk;
            result.frame_length    = state.bytes_received;
          end else begin
            result.result_kind  = KindBadEnd;
            result.frame_length = state.bytes_received;
            // A start byte where the end byte belongs opens a new frame.
            if (plain_byte == ByteStart) begin
              state_next.frame_phase     = PhaseLength;
              state_next.bytes_remaining = 7'd0;
              state_next.bytes_received  = 7'd0;
            end else begin
              state_next.frame_phase = PhaseIdle;
            end
          end
        end
      end
      default: begin
        if (rx_byte == ByteStart) begin
          state_next.frame_phase     = PhaseLength;
          state_next.escape_pending  = 1'b0;
          state_next.bytes_remaining = 7'd0;
          state_next.bytes_received  = 7'd0;
        end else if (rx_byte == ByteStop) begin
          state_next.stopped_flag = 1'b1;
          has_result              = 1'b1;
          result.result_kind      = KindFlow;
        end else if (rx_byte == ByteContinue) begin
          state_next.stopped_flag = 1'b0;
          has_result              = 1'b1;
          result.result_kind      = KindFlow;
        end else begin
          has_result         = 1'b1;
          result.result_kind = KindStray;
        end
      end
    endcase
    result.link_stopped = state_next.stopped_flag;
  end

endmodule

[sv/elfd_out_reg.sv]
// Result register that holds one result until the receiver takes it.
module elfd_out_reg
  import elfd_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  result_t        result,
  elfd_out_if.source     tx
);

  logic    held;
  result_t payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (tx.ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      payload <= result;
    end
  end

  assign tx.valid        = held;
  assign tx.result_kind  = payload.result_kind;
  assign tx.data_byte    = payload.data_byte;
  assign tx.frame_length = payload.frame_length;
  assign tx.link_stopped = payload.link_stopped;

endmodule

[sv/escaped_length_frame_deframer.sv]
// Top level of the escaped length frame deframer: input stage, frame state, result stage.
//
// The block takes received bytes on byte_chan, one per transaction, and
// rebuilds frames of the form start byte, length byte, payload, end byte,
// with an escape byte that adds an offset to the byte after it. Results
// leave on result_chan: each payload byte as it arrives, a closing result
// for a good or faulty frame, a stray-byte result and a flow-change result
// for the stop and continue bytes seen between frames.
// An accepted byte is held in the input register, is decoded against the
// frame state and its result is registered in the result register, from
// which it is offered on result_chan until it is taken. Bytes that cause
// no result (start, length, escape) simply update the state.
// Throughput is one byte per cycle while the input stage is not held.
// A byte is accepted while an earlier result still waits on result_chan;
// only when that result is stalled and the waiting byte would produce
// another one does the input stage hold, and byte_chan ready then drops.
// A synchronous reset returns the block to idle between frames, clears the
// escape flag, both counts and the stop flag, and empties both stages.
module escaped_length_frame_deframer
  import elfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  elfd_in_if.sink     byte_chan,
  elfd_out_if.source  result_chan
);

  logic         stage_valid;
  logic [7:0]   stage_byte;
  frame_state_t state;
  frame_state_t state_next;
  logic         has_result;
  result_t      result;
  logic         out_free;
  logic         advance;

  // The result register can take a new result when it is empty or being read.
  assign out_free = !result_chan.valid || result_chan.ready;
  // The staged byte is processed when it causes no result or the result has room.
  assign advance  = stage_valid && (!has_result || out_free);
  assign byte_chan.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (byte_chan.ready) begin
      stage_valid <= byte_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_chan.valid && byte_chan.ready) begin
      stage_byte <= byte_chan.rx_byte;
    end
  end

  // Frame state moves on exactly once for each processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.frame_phase     <= PhaseIdle;
      state.escape_pending  <= 1'b0;
      state.bytes_remaining <= 7'd0;
      state.bytes_received  <= 7'd0;
      state.stopped_flag    <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  elfd_step u_step (
    .rx_byte    (stage_byte),
    .state      (state),
    .state_next (state_next),
    .has_result (has_result),
    .result     (result)
  );

  elfd_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && has_result),
    .result (result),
    .tx     (result_chan)
  );

`ifndef ASSERT_OFF
  // A result is never loaded over one that is stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_chan.valid && !result_chan.ready && advance) |-> !has_result)
    else $error("result overwritten while stalled");

  // A loaded result is offered in the next cycle.
  a_result_offered: assert property (@(posedge clk) disable iff (rst)
    (advance && has_result) |=> result_chan.valid)
    else $error("loaded result not offered");

  // Payload bytes remain to be counted only inside a frame's payload.
  a_remaining_in_payload: assert property (@(posedge clk) disable iff (rst)
    (state.bytes_remaining != 7'd0) |-> (state.frame_phase == PhasePayload))
    else $error("remaining count outside payload phase");
`endif

endmodule
